### hdl/fws_pkg.sv
// Shared types, register map and command codes of the forward warp splat block.
package fws_pkg;

	localparam int FWS_MAX_COLS    = 1024;
	localparam int FWS_MAX_ROWS    = 1024;
	localparam int FWS_FRAC_BITS   = 4;
	localparam int FWS_QUEUE_DEPTH = 4;

	// configuration port
	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_OUT_COLS = 2'd0;
	localparam logic [1:0] REG_OUT_ROWS = 2'd1;
	localparam logic [1:0] REG_MARGIN   = 2'd2;

	localparam logic [10:0] OUT_COLS_RST = 11'd1024;
	localparam logic [10:0] OUT_ROWS_RST = 11'd1024;
	localparam logic [8:0]  MARGIN_RST   = 9'd200;

	// input action codes
	localparam logic [1:0] ACT_SPLAT = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// classified command codes carried from front to back
	localparam logic [1:0] OP_SPLAT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_MISS  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [9:0]         src_col;
		logic signed [15:0] warp_x;
		logic signed [15:0] warp_y;
		logic [23:0]        pixel_in;
		logic [9:0]         addr_x;
		logic [9:0]         addr_y;
	} fws_item_t;

	typedef struct packed {
		logic [23:0] pixel_out;
		logic        addr_ok;
	} fws_result_t;

	typedef struct packed {
		logic [10:0] out_cols;
		logic [10:0] out_rows;
		logic [8:0]  margin;
	} fws_cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic        left_en;
		logic [23:0] pixel;
	} fws_cmd_t;

endpackage

### hdl/fws_fifo.sv
// Short command queue between the front and the back of the splat block.
module fws_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = fws_pkg::FWS_QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [PW:0]   CAP  = (PW + 1)'(DEPTH);

	logic [W-1:0]  store_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CAP);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = store_q[rd_ptr_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/fws_front.sv
// Front of the splat block: accepts beats, places splat targets and classifies commands.
module fws_front #(
	parameter int MAX_COLS  = fws_pkg::FWS_MAX_COLS,
	parameter int MAX_ROWS  = fws_pkg::FWS_MAX_ROWS,
	parameter int FRAC_BITS = fws_pkg::FWS_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fws_pkg::fws_cfg_t                      cfg,
	input  logic                                   clearing,
	input  logic                                   push,
	output logic                                   full,
	input  fws_pkg::fws_item_t                     item,
	output logic                                   q_push,
	input  logic                                   q_full,
	output fws_pkg::fws_cmd_t                      q_cmd,
	output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]   q_addr
);
	import fws_pkg::*;

	localparam int AW   = $clog2(MAX_COLS * MAX_ROWS);
	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int LW   = $clog2(MAXD + 1);
	localparam int VW   = (((FRAC_BITS + 10) > 16) ? (FRAC_BITS + 10) : 16) + 1;
	localparam int QW   = VW + 1 - FRAC_BITS;
	localparam int KW0  = (QW > LW) ? QW : LW;
	localparam int KW   = (KW0 > 11) ? KW0 : 11;
	localparam int HALF = (1 << FRAC_BITS) >> 1;
	localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLS);

	// saturate a configured frame size to [3, mx]
	function automatic logic [KW-1:0] eff_size(input logic [10:0] r, input logic [KW-1:0] mx);
		logic [KW-1:0] rz;
		rz = KW'(r);
		if (rz < KW'(3)) begin
			eff_size = KW'(3);
		end else if (rz > mx) begin
			eff_size = mx;
		end else begin
			eff_size = rz;
		end
	endfunction

	// add margin, round half away from zero, clamp to [1, lim-2]
	function automatic logic [KW-1:0] place(input logic signed [15:0] raw,
			input logic [8:0] mrg, input logic [KW-1:0] lim);
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] moff;
		logic [VW-1:0]        mag;
		logic [VW:0]          rnd;
		logic [KW-1:0]        q;
		logic                 neg;
		moff = signed'(VW'(mrg)) <<< FRAC_BITS;
		v    = VW'(raw) + moff;
		neg  = v[VW-1];
		mag  = neg ? VW'(-v) : VW'(v);
		rnd  = {1'b0, mag} + (VW + 1)'(HALF);
		q    = KW'(rnd >> FRAC_BITS);
		if (neg || q == '0) begin
			place = KW'(1);
		end else if (q > lim - KW'(2)) begin
			place = lim - KW'(2);
		end else begin
			place = q;
		end
	endfunction

	fws_item_t     item_s1;
	logic          valid_s1;
	logic [1:0]    op_s2;
	logic          left_s2;
	logic [23:0]   pix_s2;
	logic [CW-1:0] x_s2;
	logic [RW-1:0] y_s2;
	logic          valid_s2;

	logic          ready_s2;
	logic          take;
	logic [KW-1:0] cols;
	logic [KW-1:0] rows;
	logic          in_frame;
	logic          keep;
	logic [1:0]    op_c;
	logic [KW-1:0] xs;
	logic [KW-1:0] ys;

	assign ready_s2 = !valid_s2 || !q_full;
	assign full     = clearing || (valid_s1 && !ready_s2);
	assign take     = push && !full;

	// classify the held beat and place its target
	assign cols     = eff_size(cfg.out_cols, KW'(MAX_COLS));
	assign rows     = eff_size(cfg.out_rows, KW'(MAX_ROWS));
	assign in_frame = (KW'(item_s1.addr_x) < cols) && (KW'(item_s1.addr_y) < rows);

	always_comb begin
		keep = 1'b0;
		op_c = OP_CLEAR;
		xs   = KW'(item_s1.addr_x);
		ys   = KW'(item_s1.addr_y);
		unique case (item_s1.action)
			ACT_SPLAT: begin
				keep = 1'b1;
				op_c = OP_SPLAT;
				xs   = place(item_s1.warp_x, cfg.margin, cols);
				ys   = place(item_s1.warp_y, cfg.margin, rows);
			end
			ACT_READ: begin
				keep = 1'b1;
				op_c = in_frame ? OP_READ : OP_MISS;
			end
			ACT_CLEAR: begin
				keep = in_frame;
				op_c = OP_CLEAR;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (ready_s2) begin
				valid_s1 <= 1'b0;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1 && keep;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
		if (ready_s2) begin
			op_s2   <= op_c;
			left_s2 <= (item_s1.src_col != '0);
			pix_s2  <= item_s1.pixel_in;
			x_s2    <= CW'(xs);
			y_s2    <= RW'(ys);
		end
	end

	// form the frame address into the queue
	assign q_push        = valid_s2 && !q_full;
	assign q_cmd.op      = op_s2;
	assign q_cmd.left_en = left_s2;
	assign q_cmd.pixel   = pix_s2;
	assign q_addr        = AW'(y_s2) * COL_STRIDE + AW'(x_s2);

endmodule

### hdl/fws_back.sv
// Back of the splat block: frame memory sequencer, clearing pass and result register.
module fws_back #(
	parameter int MAX_COLS = fws_pkg::FWS_MAX_COLS,
	parameter int MAX_ROWS = fws_pkg::FWS_MAX_ROWS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	input  fws_pkg::fws_cmd_t                    q_cmd,
	input  logic [$clog2(MAX_COLS*MAX_ROWS)-1:0] q_addr,
	output logic                                 q_pop,
	output logic                                 clearing,
	input  logic                                 pop,
	output logic                                 empty,
	output fws_pkg::fws_result_t                 result
);
	import fws_pkg::*;

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [AW-1:0] COL_STRIDE = AW'(MAX_COLS);
	localparam logic [AW-1:0] ONE        = AW'(1);
	localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);

	localparam logic [2:0] ST_CLR     = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_NB_RD   = 3'd2;
	localparam logic [2:0] ST_NB_WR   = 3'd3;
	localparam logic [2:0] ST_RD_WAIT = 3'd4;

	localparam logic [2:0] NB_LEFT = 3'd3;
	localparam logic [2:0] NB_LAST = 3'd7;

	logic [23:0]   mem [DEPTH];
	logic [23:0]   rdata_q;

	logic [2:0]    state_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    k_q;
	logic          out_valid_q;
	fws_result_t   result_q;
	logic [AW-1:0] cur_addr_q;
	logic [23:0]   cur_pix_q;
	logic          cur_left_q;
	logic [AW-1:0] nb_addr_q;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_addr;
	logic [23:0]   mem_wdata;
	logic          slot_free;
	logic          out_load;
	fws_result_t   out_data;
	logic [AW-1:0] nb_addr;

	assign slot_free = !out_valid_q || pop;
	assign clearing  = (state_q == ST_CLR);
	assign empty     = !out_valid_q;
	assign result    = result_q;

	// neighbor address in the order of the fill sequence
	always_comb begin
		unique case (k_q)
			3'd0: nb_addr = cur_addr_q + COL_STRIDE;
			3'd1: nb_addr = cur_addr_q - COL_STRIDE;
			3'd2: nb_addr = cur_addr_q + ONE;
			3'd3: nb_addr = cur_addr_q - ONE;
			3'd4: nb_addr = cur_addr_q + COL_STRIDE + ONE;
			3'd5: nb_addr = cur_addr_q - COL_STRIDE - ONE;
			3'd6: nb_addr = cur_addr_q - COL_STRIDE + ONE;
			3'd7: nb_addr = cur_addr_q + COL_STRIDE - ONE;
		endcase
	end

	// drive the memory port, queue pop and result load
	always_comb begin
		mem_we             = 1'b0;
		mem_re             = 1'b0;
		mem_addr           = q_addr;
		mem_wdata          = '0;
		q_pop              = 1'b0;
		out_load           = 1'b0;
		out_data.pixel_out = '0;
		out_data.addr_ok   = 1'b0;
		unique case (state_q)
			ST_CLR: begin
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			ST_IDLE: begin
				if (!q_empty) begin
					unique case (q_cmd.op)
						OP_SPLAT: begin
							mem_we    = 1'b1;
							mem_wdata = q_cmd.pixel;
							q_pop     = 1'b1;
						end
						OP_READ: begin
							if (slot_free) begin
								mem_re = 1'b1;
								q_pop  = 1'b1;
							end
						end
						OP_MISS: begin
							if (slot_free) begin
								out_load = 1'b1;
								q_pop    = 1'b1;
							end
						end
						OP_CLEAR: begin
							mem_we = 1'b1;
							q_pop  = 1'b1;
						end
					endcase
				end
			end
			ST_NB_RD: begin
				mem_re   = 1'b1;
				mem_addr = nb_addr;
			end
			ST_NB_WR: begin
				mem_addr  = nb_addr_q;
				mem_wdata = cur_pix_q;
				mem_we    = (rdata_q == '0) && ((k_q != NB_LEFT) || cur_left_q);
			end
			ST_RD_WAIT: begin
				out_load           = 1'b1;
				out_data.pixel_out = rdata_q;
				out_data.addr_ok   = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// single-port frame memory with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	// sequence the clearing pass and the splat fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ONE;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_pop && q_cmd.op == OP_SPLAT) begin
						k_q     <= '0;
						state_q <= ST_NB_RD;
					end else if (q_pop && q_cmd.op == OP_READ) begin
						state_q <= ST_RD_WAIT;
					end
				end
				ST_NB_RD: begin
					state_q <= ST_NB_WR;
				end
				ST_NB_WR: begin
					if (k_q == NB_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 3'd1;
						state_q <= ST_NB_RD;
					end
				end
				ST_RD_WAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the splat in progress and the result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop && q_cmd.op == OP_SPLAT) begin
			cur_addr_q <= q_addr;
			cur_pix_q  <= q_cmd.pixel;
			cur_left_q <= q_cmd.left_en;
		end
		if (state_q == ST_NB_RD) begin
			nb_addr_q <= nb_addr;
		end
		if (out_load) begin
			result_q <= out_data;
		end
	end

`ifndef SYNTH
	a_load_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || pop))
		else $error("result loaded over a waiting beat");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |-> !q_pop)
		else $error("command taken during clearing pass");
	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("frame memory read and written in one cycle");
	a_nb_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB_WR) |-> ($past(state_q) == ST_NB_RD))
		else $error("neighbor write without preceding read");
	a_rd_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD_WAIT) |=> out_valid_q)
		else $error("read data not presented");
`endif

endmodule

### hdl/forward_warp_splat.sv
// Top level of the forward warp splat block: register port, front, queue and back.
//
// Nearest-neighbor forward warping into a frame store of MAX_COLS x MAX_ROWS 24-bit pixels.
// After reset the frame memory is swept to black, one word a cycle; full stays high
// during that pass while register writes are taken as usual. A beat then passes the
// front's capture and placement registers, with the address formed from the placement
// register, into a four-entry command queue. In the back a splat occupies the single-port
// frame memory for one center write, then a read and a conditional write for each of
// the eight neighbors; a read takes a memory read and a wait state, a clear or an
// out-of-frame read only the idle state; that memory port sets the sustained rate. Read
// results wait in an output register while further beats are accepted.
module forward_warp_splat #(
	parameter int MAX_COLS  = fws_pkg::FWS_MAX_COLS,
	parameter int MAX_ROWS  = fws_pkg::FWS_MAX_ROWS,
	parameter int FRAC_BITS = fws_pkg::FWS_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fws_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          push,
	output logic                          full,
	input  fws_pkg::fws_item_t            item,
	output logic                          empty,
	input  logic                          pop,
	output fws_pkg::fws_result_t          result
);
	import fws_pkg::*;

	localparam int AW = $clog2(MAX_COLS * MAX_ROWS);
	localparam int CQ = $bits(fws_cmd_t) + AW;

	fws_cfg_t      cfg_q;
	logic [1:0]    reg_idx;
	logic          clearing;
	logic          f_push;
	logic          q_full;
	fws_cmd_t      f_cmd;
	logic [AW-1:0] f_addr;
	logic          q_empty;
	logic          q_pop;
	logic [CQ-1:0] q_rdata;
	fws_cmd_t      b_cmd;
	logic [AW-1:0] b_addr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.out_cols <= OUT_COLS_RST;
			cfg_q.out_rows <= OUT_ROWS_RST;
			cfg_q.margin   <= MARGIN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_OUT_COLS: cfg_q.out_cols <= pwdata[10:0];
				REG_OUT_ROWS: cfg_q.out_rows <= pwdata[10:0];
				REG_MARGIN:   cfg_q.margin   <= pwdata[8:0];
				default:      cfg_q.margin   <= cfg_q.margin;
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		unique case (reg_idx)
			REG_OUT_COLS: prdata = 32'(cfg_q.out_cols);
			REG_OUT_ROWS: prdata = 32'(cfg_q.out_rows);
			REG_MARGIN:   prdata = 32'(cfg_q.margin);
			default:      prdata = '0;
		endcase
	end

	fws_front #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.push     (push),
		.full     (full),
		.item     (item),
		.q_push   (f_push),
		.q_full   (q_full),
		.q_cmd    (f_cmd),
		.q_addr   (f_addr)
	);

	fws_fifo #(
		.W     (CQ),
		.DEPTH (FWS_QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (q_full),
		.wdata  ({f_cmd, f_addr}),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign {b_cmd, b_addr} = q_rdata;

	fws_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_cmd    (b_cmd),
		.q_addr   (b_addr),
		.q_pop    (q_pop),
		.clearing (clearing),
		.pop      (pop),
		.empty    (empty),
		.result   (result)
	);

endmodule

### verif/tb.sv
// Self-checking testbench of the forward warp splat block with a frame-store predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fws_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RAND_PER_PHASE = 225;
	localparam int TAIL_CYCLES = 160;
	localparam int CYCLE_LIMIT = 6000000;

	// Predicts the frame store and queues the results of read beats.
	class frame_predictor;
		fws_cfg_t cfg;
		bit [23:0] pix_store [int];
		fws_result_t read_expect_q[$];
		int errors;

		function new();
			cfg.out_cols = OUT_COLS_RST;
			cfg.out_rows = OUT_ROWS_RST;
			cfg.margin = MARGIN_RST;
			errors = 0;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_OUT_COLS: cfg.out_cols = val[10:0];
				REG_OUT_ROWS: cfg.out_rows = val[10:0];
				REG_MARGIN: cfg.margin = val[8:0];
				default: ;
			endcase
		endfunction

		function int eff_cols();
			int c = cfg.out_cols;
			if (c < 3) c = 3;
			if (c > FWS_MAX_COLS) c = FWS_MAX_COLS;
			return c;
		endfunction

		function int eff_rows();
			int r = cfg.out_rows;
			if (r < 3) r = 3;
			if (r > FWS_MAX_ROWS) r = FWS_MAX_ROWS;
			return r;
		endfunction

		// Add the margin, round half away from zero, clamp to [1, lim-2].
		function int place_coord(logic signed [15:0] w, int lim);
			int half;
			int v;
			int q;
			half = (FWS_FRAC_BITS > 0) ? (1 << (FWS_FRAC_BITS - 1)) : 0;
			v = int'(w) + (int'(cfg.margin) << FWS_FRAC_BITS);
			q = ((v < 0 ? -v : v) + half) >>> FWS_FRAC_BITS;
			if (v < 0) q = -q;
			if (q < 1) q = 1;
			if (q > lim - 2) q = lim - 2;
			return q;
		endfunction

		function int cell_idx(int x, int y);
			return y * FWS_MAX_COLS + x;
		endfunction

		function bit [23:0] peek(int i);
			return pix_store.exists(i) ? pix_store[i] : 24'd0;
		endfunction

		function void fill_black(int x, int y, bit [23:0] p);
			if (peek(cell_idx(x, y)) == 24'd0) pix_store[cell_idx(x, y)] = p;
		endfunction

		// Apply one accepted beat to the store; queue a result for reads.
		function void note_item(fws_item_t it);
			int cols;
			int rows;
			int x;
			int y;
			fws_result_t r;
			cols = eff_cols();
			rows = eff_rows();
			case (it.action)
				ACT_SPLAT: begin
					x = place_coord(it.warp_x, cols);
					y = place_coord(it.warp_y, rows);
					pix_store[cell_idx(x, y)] = it.pixel_in;
					fill_black(x, y + 1, it.pixel_in);
					fill_black(x, y - 1, it.pixel_in);
					fill_black(x + 1, y, it.pixel_in);
					if (it.src_col != 0) fill_black(x - 1, y, it.pixel_in);
					fill_black(x + 1, y + 1, it.pixel_in);
					fill_black(x - 1, y - 1, it.pixel_in);
					fill_black(x + 1, y - 1, it.pixel_in);
					fill_black(x - 1, y + 1, it.pixel_in);
				end
				ACT_READ: begin
					if (int'(it.addr_x) < cols && int'(it.addr_y) < rows) begin
						r.pixel_out = peek(cell_idx(it.addr_x, it.addr_y));
						r.addr_ok = 1'b1;
					end else begin
						r.pixel_out = 24'd0;
						r.addr_ok = 1'b0;
					end
					read_expect_q.push_back(r);
				end
				ACT_CLEAR: begin
					if (int'(it.addr_x) < cols && int'(it.addr_y) < rows)
						pix_store[cell_idx(it.addr_x, it.addr_y)] = 24'd0;
				end
				default: ;
			endcase
		endfunction

		// Compare one popped result with the oldest pending read.
		task check_result(fws_result_t got);
			fws_result_t exp;
			if (read_expect_q.size() == 0) begin
				report($sformatf("result %h/%b with no read pending", got.pixel_out, got.addr_ok));
			end else begin
				exp = read_expect_q.pop_front();
				if (got.pixel_out !== exp.pixel_out)
					report($sformatf("pixel_out %h, want %h", got.pixel_out, exp.pixel_out));
				if (got.addr_ok !== exp.addr_ok)
					report($sformatf("addr_ok %b, want %b", got.addr_ok, exp.addr_ok));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	fws_item_t item = '0;
	logic empty;
	logic pop = 1'b0;
	fws_result_t result;

	frame_predictor model;
	int send_idle = 29;
	int recv_idle = 70;
	int cycle_cnt = 0;
	int hist_x [8];
	int hist_y [8];
	int hist_n = 0;

	int ph_cols [6] = '{16, 3, 0, 2047, 1024, 1025};
	int ph_rows [6] = '{12, 3, 2047, 1, 1024, 37};
	int ph_margin [6] = '{4, 0, 511, 100, 200, 511};

	forward_warp_splat u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Pop result beats with random stalls and check each one.
	initial begin
		forever begin
			pop <= ($urandom_range(0, 99) >= recv_idle);
			@(posedge clk);
			if (pop && !empty) model.check_result(result);
		end
	end

	task reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		model.set_reg(idx, val);
		@(posedge clk);
	endtask

	task reg_readback(input logic [1:0] idx, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			model.report($sformatf("register %0d reads %h, want %h", idx, prdata, want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write all three registers, then read them back.
	task set_config(input int cols, input int rows, input int mrg);
		reg_write(REG_OUT_COLS, 32'(cols));
		reg_write(REG_OUT_ROWS, 32'(rows));
		reg_write(REG_MARGIN, 32'(mrg));
		reg_readback(REG_OUT_COLS, 32'(model.cfg.out_cols));
		reg_readback(REG_OUT_ROWS, 32'(model.cfg.out_rows));
		reg_readback(REG_MARGIN, 32'(model.cfg.margin));
	endtask

	// Push one beat after a random gap; hold it until accepted.
	task send_item(input fws_item_t it);
		while ($urandom_range(0, 99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		model.note_item(it);
	endtask

	// Wait for every pending read, then let queued splats and clears finish.
	task drain();
		push <= 1'b0;
		while (model.read_expect_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	function fws_item_t random_fields();
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		return r[87:0];
	endfunction

	function fws_item_t mk_splat(int src, int wx, int wy, logic [23:0] pix);
		fws_item_t it;
		it = random_fields();
		it.action = ACT_SPLAT;
		it.src_col = 10'(src);
		it.warp_x = 16'(wx);
		it.warp_y = 16'(wy);
		it.pixel_in = pix;
		return it;
	endfunction

	function fws_item_t mk_access(logic [1:0] act, int x, int y);
		fws_item_t it;
		it = random_fields();
		it.action = act;
		it.addr_x = 10'(x);
		it.addr_y = 10'(y);
		return it;
	endfunction

	// Warp value that lands near target t, with a random fraction around the half.
	function logic signed [15:0] aim(int t);
		int w;
		w = ((t - int'(model.cfg.margin)) << FWS_FRAC_BITS) + $urandom_range(0, 16) - 8;
		if (w > 32767) w = 32767;
		if (w < -32768) w = -32768;
		return w[15:0];
	endfunction

	// Splats mostly aimed onto the frame, reads or clears mostly around recent splats, and an occasional unused action.
	function fws_item_t gen_item();
		fws_item_t it;
		int pick;
		int k;
		it = random_fields();
		pick = $urandom_range(0, 99);
		if (pick < 46) begin
			it.action = ACT_SPLAT;
			if ($urandom_range(0, 4) != 0) begin
				it.warp_x = aim($urandom_range(0, model.eff_cols() - 1));
				it.warp_y = aim($urandom_range(0, model.eff_rows() - 1));
			end
			hist_x[hist_n % 8] = model.place_coord(it.warp_x, model.eff_cols());
			hist_y[hist_n % 8] = model.place_coord(it.warp_y, model.eff_rows());
			hist_n++;
		end else begin
			if (pick < 80) it.action = ACT_READ;
			else if (pick < 96) it.action = ACT_CLEAR;
			else it.action = ACT_UNUSED;
			if (hist_n > 0 && $urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, (hist_n < 8 ? hist_n : 8) - 1);
				it.addr_x = 10'(hist_x[k] + $urandom_range(0, 2) - 1);
				it.addr_y = 10'(hist_y[k] + $urandom_range(0, 2) - 1);
			end
		end
		return it;
	endfunction

	initial begin
		fws_item_t it;
		int n;
		model = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats on an 8x6 frame with margin 2.
		set_config(8, 6, 2);
		send_item(mk_splat(0, 24, 16, 24'hFFFFFF));
		send_item(mk_access(ACT_READ, 3, 3));
		send_item(mk_access(ACT_READ, 5, 3));
		send_item(mk_access(ACT_READ, 4, 2));
		send_item(mk_access(ACT_READ, 3, 4));
		send_item(mk_splat(1023, -32768, 32767, 24'h123456));
		send_item(mk_access(ACT_READ, 0, 4));
		send_item(mk_access(ACT_READ, 0, 5));
		send_item(mk_splat(1, 32767, -32768, 24'h000000));
		send_item(mk_access(ACT_READ, 6, 1));
		send_item(mk_access(ACT_READ, 7, 0));
		send_item(mk_splat(5, -40, -8, 24'hABCDEF));
		send_item(mk_access(ACT_READ, 0, 2));
		send_item(mk_access(ACT_READ, 8, 0));
		send_item(mk_access(ACT_READ, 1023, 1023));
		send_item(mk_access(ACT_READ, 7, 5));
		send_item(mk_access(ACT_CLEAR, 4, 3));
		send_item(mk_access(ACT_READ, 4, 3));
		send_item(mk_access(ACT_CLEAR, 1023, 5));
		send_item(mk_access(ACT_READ, 1, 4));
		send_item(mk_access(ACT_UNUSED, 4, 2));
		send_item(mk_access(ACT_READ, 4, 2));
		send_item(mk_access(ACT_CLEAR, 0, 0));
		send_item(mk_access(ACT_READ, 0, 0));
		drain();

		// Random phases: two per idle mode, a new frame setting each.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin send_idle = 29; recv_idle = 70; end
				1: begin send_idle = 70; recv_idle = 29; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			set_config(ph_cols[ph], ph_rows[ph], ph_margin[ph]);
			n = 0;
			while (n < RAND_PER_PHASE) begin
				it = gen_item();
				send_item(it);
				if (it.action != ACT_UNUSED) n++;
			end
			drain();
		end

		if (model.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

### filelist.f
hdl/fws_pkg.sv
hdl/fws_fifo.sv
hdl/fws_front.sv
hdl/fws_back.sv
hdl/forward_warp_splat.sv
verif/tb.sv
